// ===== hdl/pptd_pkg.sv =====
// ----------------------------------------------------------------------------
// Priority periodic task dispatcher package
// Shared sizes, codes and beat payload types for the dispatcher and its
// due-check unit.
// ----------------------------------------------------------------------------
package pptd_pkg;

   // Table size and the widths that follow from it.
   localparam int MAX_TASKS = 5;
   localparam int SLOT_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int COUNT_W   = $clog2(MAX_TASKS + 1);

   // Fixed field widths.
   localparam int PRIO_W  = 8;
   localparam int TIME_W  = 32;
   localparam int TYPE_W  = 3;
   localparam int ORDER_W = 3;

   // Request kinds.
   localparam logic KIND_ADD  = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // Reply kinds.
   localparam logic REPLY_ADD      = 1'b0;
   localparam logic REPLY_DISPATCH = 1'b1;

   // Task types up to this code map to known actions.
   localparam logic [TYPE_W-1:0] LAST_KNOWN_TYPE = 3'd3;

   typedef logic [SLOT_W-1:0]  slot_idx_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [TIME_W-1:0]  time_type;

   // Input beat.
   typedef struct packed {
      logic               kind;
      logic [PRIO_W-1:0]  task_priority_in;
      logic [TIME_W-1:0]  task_interval_in;
      logic [TYPE_W-1:0]  task_type_in;
      logic [TIME_W-1:0]  task_last_run_in;
      logic [TIME_W-1:0]  current_time;
   } req_type;

   // Result beat.
   typedef struct packed {
      logic               reply_kind;
      logic               accepted;
      logic [TYPE_W-1:0]  due_task_type;
      logic               type_known;
      logic [ORDER_W-1:0] dispatch_order;
      logic               last_of_run;
   } rsp_type;

endpackage

// ===== hdl/pptd_due_unit.sv =====
// ----------------------------------------------------------------------------
// Due-check unit
// Shared subtract and compare: a task is due when the wrapped time since its
// last run is strictly greater than its interval.
// ----------------------------------------------------------------------------
module pptd_due_unit (
   input  pptd_pkg::time_type now,
   input  pptd_pkg::time_type last_run,
   input  pptd_pkg::time_type interval,
   output logic               due
);

   pptd_pkg::time_type elapsed;

   // Modulo 2^32 elapsed time, then a strict unsigned compare.
   assign elapsed = now - last_run;
   assign due     = (elapsed > interval);

endmodule

// ===== hdl/priority_periodic_task_dispatcher.sv =====
// ----------------------------------------------------------------------------
// Priority periodic task dispatcher
// Holds up to MAX_TASKS periodic tasks with a priority-sorted slot list and
// dispatches due tasks on each tick through one shared due-check unit.
// ----------------------------------------------------------------------------
// Add: up to used_count + 1 insertion steps in S_INSERT, then the registered reply
//    beat from S_ADD_RESP; a refused add goes straight to S_ADD_RESP.
// Tick: one slot per cycle through the shared subtract/compare unit, unless a due slot
//    waits on a held reply beat, then S_FLUSH sends the last dispatch beat.
// An empty-table tick returns no beat; a result held by low rsp_ready stretches both.
// Reset clears the control state and the slot count; slot contents are not cleared.
// ----------------------------------------------------------------------------
module priority_periodic_task_dispatcher (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pptd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pptd_pkg::rsp_type rsp_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_INSERT,
      S_ADD_RESP,
      S_WALK,
      S_FLUSH
   } state_type;

   // Control and registered outputs.
   state_type                      state_ff, state_in;
   pptd_pkg::count_type            count_ff, count_in;
   pptd_pkg::count_type            walk_idx_ff, walk_idx_in;
   pptd_pkg::slot_idx_type         ins_idx_ff, ins_idx_in;
   logic [pptd_pkg::PRIO_W-1:0]    new_prio_ff, new_prio_in;
   pptd_pkg::time_type             now_ff, now_in;
   logic                           add_ok_ff, add_ok_in;
   logic                           pend_valid_ff, pend_valid_in;
   logic [pptd_pkg::TYPE_W-1:0]    pend_type_ff, pend_type_in;
   logic [pptd_pkg::ORDER_W-1:0]   pend_order_ff, pend_order_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   pptd_pkg::rsp_type              rsp_data_ff, rsp_data_in;

   // Task table and the priority-sorted list of slot indices.
   logic [pptd_pkg::PRIO_W-1:0]    slot_priority_ff [pptd_pkg::MAX_TASKS];
   pptd_pkg::time_type             slot_interval_ff [pptd_pkg::MAX_TASKS];
   logic [pptd_pkg::TYPE_W-1:0]    slot_type_ff     [pptd_pkg::MAX_TASKS];
   pptd_pkg::time_type             slot_last_run_ff [pptd_pkg::MAX_TASKS];
   pptd_pkg::slot_idx_type         rank_ff          [pptd_pkg::MAX_TASKS];

   // Table write controls.
   logic                           slot_we;
   logic                           stamp_we;
   logic                           rank_we;
   pptd_pkg::slot_idx_type         rank_widx;
   pptd_pkg::slot_idx_type         rank_wdata;

   // Datapath helpers.
   logic                           out_free;
   pptd_pkg::slot_idx_type         new_slot;
   pptd_pkg::slot_idx_type         walk_slot;
   pptd_pkg::count_type            walk_next;
   logic                           walk_done;
   pptd_pkg::slot_idx_type         ins_prev;
   pptd_pkg::slot_idx_type         prev_slot;
   logic                           shift_needed;
   logic                           due;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign new_slot  = count_ff[pptd_pkg::SLOT_W-1:0];
   assign walk_slot = rank_ff[walk_idx_ff[pptd_pkg::SLOT_W-1:0]];
   assign walk_next = walk_idx_ff + pptd_pkg::COUNT_W'(1);
   assign walk_done = (walk_next == count_ff);

   // Insertion compares the new priority with the entry just above it.
   assign ins_prev     = ins_idx_ff - pptd_pkg::SLOT_W'(1);
   assign prev_slot    = rank_ff[ins_prev];
   assign shift_needed = (ins_idx_ff != '0) && (slot_priority_ff[prev_slot] > new_prio_ff);

   // Shared due check on the slot at the current walk position.
   pptd_due_unit u_due (
      .now      (now_ff),
      .last_run (slot_last_run_ff[walk_slot]),
      .interval (slot_interval_ff[walk_slot]),
      .due      (due)
   );

   // Sequencer next-state logic.
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      walk_idx_in   = walk_idx_ff;
      ins_idx_in    = ins_idx_ff;
      new_prio_in   = new_prio_ff;
      now_in        = now_ff;
      add_ok_in     = add_ok_ff;
      pend_valid_in = pend_valid_ff;
      pend_type_in  = pend_type_ff;
      pend_order_in = pend_order_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      slot_we       = 1'b0;
      stamp_we      = 1'b0;
      rank_we       = 1'b0;
      rank_widx     = ins_idx_ff;
      rank_wdata    = new_slot;

      // A taken result beat frees the output register.
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_data.kind == pptd_pkg::KIND_ADD) begin
                  if (count_ff == pptd_pkg::COUNT_W'(pptd_pkg::MAX_TASKS)) begin
                     add_ok_in = 1'b0;
                     state_in  = S_ADD_RESP;
                  end else begin
                     slot_we     = 1'b1;
                     new_prio_in = req_data.task_priority_in;
                     ins_idx_in  = new_slot;
                     state_in    = S_INSERT;
                  end
               end else begin
                  now_in        = req_data.current_time;
                  walk_idx_in   = '0;
                  pend_valid_in = 1'b0;
                  state_in      = (count_ff == '0) ? S_IDLE : S_WALK;
               end
            end
         end

         S_INSERT: begin
            // Stable insertion: move entries of higher priority down by one.
            rank_we   = 1'b1;
            rank_widx = ins_idx_ff;
            if (shift_needed) begin
               rank_wdata = prev_slot;
               ins_idx_in = ins_prev;
            end else begin
               rank_wdata = new_slot;
               count_in   = count_ff + pptd_pkg::COUNT_W'(1);
               add_ok_in  = 1'b1;
               state_in   = S_ADD_RESP;
            end
         end

         S_ADD_RESP: begin
            if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.reply_kind      = pptd_pkg::REPLY_ADD;
               rsp_data_in.accepted        = add_ok_ff;
               rsp_data_in.due_task_type   = '0;
               rsp_data_in.type_known      = 1'b0;
               rsp_data_in.dispatch_order  = '0;
               rsp_data_in.last_of_run     = 1'b1;
               state_in                    = S_IDLE;
            end
         end

         S_WALK: begin
            // A due task is held back one step so the final one can be marked.
            if (!(due && pend_valid_ff && !out_free)) begin
               if (due) begin
                  stamp_we = 1'b1;
                  if (pend_valid_ff) begin
                     rsp_valid_in                = 1'b1;
                     rsp_data_in.reply_kind      = pptd_pkg::REPLY_DISPATCH;
                     rsp_data_in.accepted        = 1'b0;
                     rsp_data_in.due_task_type   = pend_type_ff;
                     rsp_data_in.type_known      = (pend_type_ff <= pptd_pkg::LAST_KNOWN_TYPE);
                     rsp_data_in.dispatch_order  = pend_order_ff;
                     rsp_data_in.last_of_run     = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_type_in  = slot_type_ff[walk_slot];
                  pend_order_in = pptd_pkg::ORDER_W'(walk_idx_ff);
               end
               walk_idx_in = walk_next;
               if (walk_done) begin
                  state_in = S_FLUSH;
               end
            end
         end

         S_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.reply_kind      = pptd_pkg::REPLY_DISPATCH;
               rsp_data_in.accepted        = 1'b0;
               rsp_data_in.due_task_type   = pend_type_ff;
               rsp_data_in.type_known      = (pend_type_ff <= pptd_pkg::LAST_KNOWN_TYPE);
               rsp_data_in.dispatch_order  = pend_order_ff;
               rsp_data_in.last_of_run     = 1'b1;
               pend_valid_in               = 1'b0;
               state_in                    = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Sequencer state and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      walk_idx_ff   <= walk_idx_in;
      ins_idx_ff    <= ins_idx_in;
      new_prio_ff   <= new_prio_in;
      now_ff        <= now_in;
      add_ok_ff     <= add_ok_in;
      pend_type_ff  <= pend_type_in;
      pend_order_ff <= pend_order_in;
      rsp_data_ff   <= rsp_data_in;
   end

   // Task table and sorted list writes; contents need no reset.
   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_priority_ff[new_slot] <= req_data.task_priority_in;
         slot_interval_ff[new_slot] <= req_data.task_interval_in;
         slot_type_ff[new_slot]     <= req_data.task_type_in;
         slot_last_run_ff[new_slot] <= req_data.task_last_run_in;
      end
      if (stamp_we) begin
         slot_last_run_ff[walk_slot] <= now_ff;
      end
      if (rank_we) begin
         rank_ff[rank_widx] <= rank_wdata;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== tb/tb_priority_periodic_task_dispatcher.sv =====
// ----------------------------------------------------------------------------
// Priority periodic task dispatcher testbench
// Fills the task table with tasks chosen to hit the priority, interval, type
// and last-run extremes and priority ties, then checks refused adds and a long
// run of time ticks against a local prediction of every reply beat. Ticks
// cover repeated times, big jumps and 32-bit wrap. Both channels stall at
// random, including one long hold-off on the reply side.
// ----------------------------------------------------------------------------
module tb_priority_periodic_task_dispatcher;
   timeunit 1ns;
   timeprecision 1ps;

   import pptd_pkg::*;

   // One queued request beat; drain_first holds it back until every reply
   // expected so far has arrived.
   typedef struct {
      req_type beat;
      bit      drain_first;
   } pending_beat_t;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Local copy of the task table.
   logic [PRIO_W-1:0] slot_prio     [MAX_TASKS];
   logic [TIME_W-1:0] slot_period   [MAX_TASKS];
   logic [TYPE_W-1:0] slot_kind     [MAX_TASKS];
   logic [TIME_W-1:0] slot_last_run [MAX_TASKS];
   int unsigned       stored_tasks = 0;

   pending_beat_t offer_queue[$];
   rsp_type       awaited_replies[$];

   int fault_count     = 0;
   int beats_sent      = 0;
   int adds_stored     = 0;
   int adds_refused    = 0;
   int ticks_sent      = 0;
   int replies_checked = 0;
   int dispatches_seen = 0;

   int   burst_left = 0;
   int   gap_left   = 0;
   int   ready_mode = 0;
   int   ready_phase = 0;
   logic long_hold  = 1'b0;

   priority_periodic_task_dispatcher DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Clock with a 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Reset is held at the start of the run only.
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // Prints one line per mismatch, up to a cap, and counts every one.
   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      fault_count++;
      if (fault_count <= 40)
         $display("%0t ns mismatch: %s got %0d expected %0d", $time, what, got, want);
   endtask

   // Applies one accepted request beat to the local table and queues the
   // replies it must produce.
   task automatic predict_replies(input req_type beat);
      int unsigned       rank [MAX_TASKS];
      rsp_type           due  [MAX_TASKS];
      rsp_type           answer;
      int unsigned       i, j, s, hits;
      logic [TIME_W-1:0] elapsed;
      if (beat.kind == KIND_ADD) begin
         answer = '0;
         answer.reply_kind  = REPLY_ADD;
         answer.last_of_run = 1'b1;
         if (stored_tasks < MAX_TASKS) begin
            slot_prio[stored_tasks]     = beat.task_priority_in;
            slot_period[stored_tasks]   = beat.task_interval_in;
            slot_kind[stored_tasks]     = beat.task_type_in;
            slot_last_run[stored_tasks] = beat.task_last_run_in;
            stored_tasks++;
            answer.accepted = 1'b1;
            adds_stored++;
         end else begin
            adds_refused++;
         end
         awaited_replies.push_back(answer);
      end else begin
         ticks_sent++;
         // Order slots by priority; equal priorities keep insertion order.
         for (i = 0; i < stored_tasks; i++) begin
            j = i;
            while (j > 0 && slot_prio[rank[j-1]] > slot_prio[i]) begin
               rank[j] = rank[j-1];
               j--;
            end
            rank[j] = i;
         end
         // A task is due when the wrapped elapsed time exceeds its period.
         hits = 0;
         for (i = 0; i < stored_tasks; i++) begin
            s = rank[i];
            elapsed = beat.current_time - slot_last_run[s];
            if (elapsed > slot_period[s]) begin
               due[hits] = '0;
               due[hits].reply_kind     = REPLY_DISPATCH;
               due[hits].due_task_type  = slot_kind[s];
               due[hits].type_known     = (slot_kind[s] <= LAST_KNOWN_TYPE);
               due[hits].dispatch_order = ORDER_W'(i);
               slot_last_run[s] = beat.current_time;
               hits++;
            end
         end
         if (hits > 0)
            due[hits-1].last_of_run = 1'b1;
         for (i = 0; i < hits; i++)
            awaited_replies.push_back(due[i]);
      end
   endtask

   // Builds an add beat; the tick time is filled with noise.
   function automatic req_type add_beat(input logic [PRIO_W-1:0] prio,
                                        input logic [TIME_W-1:0] period,
                                        input logic [TYPE_W-1:0] kind_code,
                                        input logic [TIME_W-1:0] last_run);
      req_type b;
      b.kind             = KIND_ADD;
      b.task_priority_in = prio;
      b.task_interval_in = period;
      b.task_type_in     = kind_code;
      b.task_last_run_in = last_run;
      b.current_time     = $urandom();
      return b;
   endfunction

   // Builds a tick beat; the task fields are filled with noise.
   function automatic req_type tick_beat(input logic [TIME_W-1:0] now);
      req_type b;
      b.kind             = KIND_TICK;
      b.task_priority_in = $urandom_range(0, 255);
      b.task_interval_in = $urandom();
      b.task_type_in     = $urandom_range(0, 7);
      b.task_last_run_in = $urandom();
      b.current_time     = now;
      return b;
   endfunction

   task automatic queue_beat(input req_type beat, input bit drain_first);
      pending_beat_t p;
      p.beat        = beat;
      p.drain_first = drain_first;
      offer_queue.push_back(p);
   endtask

   // Request driver: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         req_data   <= '0;
         burst_left = $urandom_range(1, 16);
         gap_left   = 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_replies(req_data);
            beats_sent++;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (offer_queue.size() == 0 ||
                         (offer_queue[0].drain_first && awaited_replies.size() != 0)) begin
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_data  <= offer_queue[0].beat;
               offer_queue.delete(0);
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 16);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
         end
      end
   end

   // Reply monitor: checks each beat against the oldest expectation and
   // stalls on a randomly chosen pattern that is redrawn periodically.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            replies_checked++;
            if (rsp_data.reply_kind == REPLY_DISPATCH)
               dispatches_seen++;
            if (awaited_replies.size() == 0) begin
               report_mismatch("reply beat with nothing pending", rsp_data, 0);
            end else begin
               want = awaited_replies.pop_front();
               if (rsp_data.reply_kind !== want.reply_kind)
                  report_mismatch("reply_kind", rsp_data.reply_kind, want.reply_kind);
               if (rsp_data.accepted !== want.accepted)
                  report_mismatch("accepted", rsp_data.accepted, want.accepted);
               if (rsp_data.due_task_type !== want.due_task_type)
                  report_mismatch("due_task_type", rsp_data.due_task_type,
                                  want.due_task_type);
               if (rsp_data.type_known !== want.type_known)
                  report_mismatch("type_known", rsp_data.type_known, want.type_known);
               if (rsp_data.dispatch_order !== want.dispatch_order)
                  report_mismatch("dispatch_order", rsp_data.dispatch_order,
                                  want.dispatch_order);
               if (rsp_data.last_of_run !== want.last_of_run)
                  report_mismatch("last_of_run", rsp_data.last_of_run, want.last_of_run);
            end
         end
         ready_phase++;
         if (ready_phase % 48 == 0)
            ready_mode = $urandom_range(0, 3);
         if (long_hold) begin
            rsp_ready <= 1'b0;
         end else begin
            case (ready_mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= $urandom_range(0, 1);
               2: rsp_ready <= (ready_phase % 4 == 0);
               default: rsp_ready <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // One long reply hold-off while requests keep coming, so the block backs up.
   initial begin
      wait (beats_sent >= 80);
      @(posedge clock);
      long_hold <= 1'b1;
      repeat (300) @(posedge clock);
      long_hold <= 1'b0;
   end

   // Stimulus and end of run.
   initial begin
      logic [TIME_W-1:0] clock_s;
      int                n, pick;

      // Directed part: empty table, the table filling up, refused adds and
      // ticks at the edges of the time range.
      queue_beat(tick_beat(32'd100), 1'b0);
      queue_beat(add_beat(8'h80, 32'd0, 3'd7, 32'd0), 1'b0);
      queue_beat(tick_beat(32'd0), 1'b0);
      queue_beat(tick_beat(32'd1), 1'b0);
      queue_beat(add_beat(8'hFF, 32'hFFFF_FFFE, 3'd0, 32'hFFFF_FFFF), 1'b0);
      queue_beat(add_beat(8'h00, 32'd5, 3'd3, 32'hFFFF_FFFE), 1'b0);
      queue_beat(add_beat(8'h80, 32'd2, 3'd4, 32'd0), 1'b0);
      queue_beat(add_beat(8'h7F, 32'd1, 3'd1, 32'hFFFF_FFF0), 1'b0);
      queue_beat(add_beat(8'hFF, 32'hFFFF_FFFF, 3'd7, 32'hFFFF_FFFF), 1'b0);
      queue_beat(tick_beat(32'd4), 1'b0);
      queue_beat(tick_beat(32'd4), 1'b0);
      // Only here does the near-maximal period run out.
      queue_beat(tick_beat(32'hFFFF_FFFE), 1'b0);
      queue_beat(tick_beat(32'hFFFF_FFFF), 1'b0);
      queue_beat(tick_beat(32'd0), 1'b0);
      queue_beat(add_beat(8'h00, 32'd0, 3'd0, 32'd0), 1'b0);

      // Random part: mostly a steadily advancing clock, with repeated times,
      // random jumps, a run over the wrap and some refused adds.
      clock_s = 32'd1;
      for (n = 0; n < 285; n++) begin
         pick = $urandom_range(0, 99);
         if (n == 170)
            clock_s = 32'hFFFF_FFF6;
         if (pick < 6) begin
            queue_beat(add_beat($urandom_range(0, 255), $urandom(),
                                $urandom_range(0, 7), $urandom()), n == 150);
         end else begin
            if (pick < 10)
               clock_s = $urandom();
            else if (pick >= 14)
               clock_s = clock_s + $urandom_range(1, 6);
            queue_beat(tick_beat(clock_s), n == 150);
         end
      end

      // Wait for everything to be sent and answered, then let the block settle.
      while (offer_queue.size() != 0 || req_valid || awaited_replies.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      if (awaited_replies.size() != 0)
         report_mismatch("replies never delivered", awaited_replies.size(), 0);

      $display("Sent %0d beats: %0d adds stored, %0d adds refused, %0d ticks.",
               beats_sent, adds_stored, adds_refused, ticks_sent);
      $display("Checked %0d reply beats, %0d of them task dispatches.",
               replies_checked, dispatches_seen);
      if (fault_count == 0)
         $display("** priority_periodic_task_dispatcher: PASSED **");
      else
         $display("** priority_periodic_task_dispatcher: FAILED **");
      $finish;
   end

   // Watchdog on the whole run.
   initial begin
      #2_000_000;
      $display("** priority_periodic_task_dispatcher: FAILED **");
      $finish;
   end

endmodule
